// File: design/tcts_pkg.sv
package tcts_pkg;

    localparam int THREAD_SLOTS_DEF = 16;

    localparam int OP_W      = 3;
    localparam int SLOT_W    = 4;
    localparam int PRIO_W    = 6;
    localparam int CREDIT_W  = 7;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    // wide enough to compare a slot field against any supported slot count
    localparam int CMP_W     = 9;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX     = 7'd127;
    localparam logic [PRIO_W-1:0]   DEF_PRIO_RST   = 6'd8;
    localparam logic [PRIO_W-1:0]   PRIO_LIMIT_RST = 6'd63;
    localparam logic [CREDIT_W-1:0] MIN_CREDIT_RST = 7'd4;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_READY    = 3'd1,
        OP_UNREADY  = 3'd2,
        OP_SET_PRIO = 3'd3,
        OP_SCHEDULE = 3'd4,
        OP_FREE     = 3'd5,
        OP_UNDEF6   = 3'd6,
        OP_UNDEF7   = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NO_CREDIT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEF_PRIO   = 2'd0,
        CFG_PRIO_LIMIT = 2'd1,
        CFG_MIN_CREDIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        COND_UNUSED = 2'd0,
        COND_LIVE   = 2'd1,
        COND_READY  = 2'd2,
        COND_DEAD   = 2'd3
    } t_cond;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [CREDIT_W-1:0] credit;
        t_cond               cond;
    } t_entry;

endpackage

// File: design/tcts_slot_table.sv
module tcts_slot_table #(
    parameter int THREAD_SLOTS = tcts_pkg::THREAD_SLOTS_DEF,
    localparam int AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output tcts_pkg::t_entry o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  tcts_pkg::t_entry i_wr_data
);

    tcts_pkg::t_entry        r_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] r_vld;
    tcts_pkg::t_entry        r_rdata;
    logic                    r_rvld;

    // an entry never written reads as zero priority, zero credit, unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
            r_rvld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

// File: design/tcts_run_list.sv
module tcts_run_list #(
    parameter int THREAD_SLOTS = tcts_pkg::THREAD_SLOTS_DEF,
    localparam int AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [AW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_wr_data
);

    logic [AW-1:0] r_mem [THREAD_SLOTS];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

// File: design/tick_credit_thread_scheduler_unit.sv
// thread slot scheduler with tick credits
// input channel (i_in_valid / o_in_ready) takes one op word: create, ready,
// unready, set_prio, schedule or free on a slot; output channel
// (o_out_valid / i_out_ready) returns exactly one result word per op word.
// config registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// one op word is in flight at a time; o_in_ready is high only when idle.
// after the result register loads, the unit is back in idle and can accept the next op word.
// unknown op, slot out of range or schedule on an empty list: no memory read.
// create, ready, set_prio, and unready or free of an unlisted slot: a
// registered read of the slot table entry.
// unready or free of a listed slot: a walk over the run list, one run list
// entry read and shifted per cycle.
// schedule: a walk over the run list, and a second, recompute pass when all
// credits are zero; each pass reads one run list entry per cycle and its
// slot table entry in the cycle after.
// reset clears the run count and the slot table valid bits and loads the
// config registers with their reset values; no clearing pass is needed.
// the result sits in an output register, so a stalled receiver does not
// block acceptance of the next op word; only the following result waits.
module tick_credit_thread_scheduler_unit #(
    parameter int THREAD_SLOTS = tcts_pkg::THREAD_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcts_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcts_pkg::OP_W-1:0]      i_op,
    input  logic [tcts_pkg::SLOT_W-1:0]    i_slot,
    input  logic [tcts_pkg::PRIO_W-1:0]    i_new_priority,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcts_pkg::STATUS_W-1:0]  o_status,
    output logic [tcts_pkg::SLOT_W-1:0]    o_picked_slot,
    output logic                           o_picked_valid,
    output logic                           o_recomputed
);

    localparam int AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int PW = tcts_pkg::PRIO_W;
    localparam int CRW = tcts_pkg::CREDIT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        W_SEARCH = 2'd0,
        W_RECOMP = 2'd1,
        W_REMOVE = 2'd2
    } t_walk;

    typedef struct packed {
        tcts_pkg::t_status status;
        logic [AW-1:0]     pick;
        logic              picked;
        logic              recomp;
    } t_result;

    // config
    logic [PW-1:0]  r_def_prio;
    logic [PW-1:0]  r_prio_limit;
    logic [CRW-1:0] r_min_credit;

    // control and working registers
    t_state         r_state, n_state;
    tcts_pkg::t_op  r_op, n_op;
    logic [AW-1:0]  r_sidx, n_sidx;
    logic [PW-1:0]  r_np, n_np;
    logic [AW:0]    r_count, n_count;
    t_walk          r_mode, n_mode;
    logic [AW:0]    r_idx, n_idx;
    logic           r_v1, n_v1;
    logic [AW:0]    r_j1, n_j1;
    logic           r_v2, n_v2;
    logic [AW-1:0]  r_s2, n_s2;
    logic           r_found, n_found;
    logic [CRW-1:0] r_best, n_best;
    logic [AW-1:0]  r_pick, n_pick;
    t_result        r_res, n_res;
    t_result        r_out, n_out;
    logic           r_out_valid, n_out_valid;

    // memory ports
    logic             st_rd_en, st_wr_en;
    logic [AW-1:0]    st_rd_addr, st_wr_addr;
    tcts_pkg::t_entry st_rdata, st_wr_data;
    logic             rl_rd_en, rl_wr_en;
    logic [AW-1:0]    rl_rd_addr, rl_wr_addr, rl_wr_data, rl_rdata;

    logic           accept;
    logic           in_range;
    logic           slot_valid;
    logic           walk_end;
    logic [CRW-1:0] floor_credit;
    logic [CRW:0]   half_sum;
    logic [CRW-1:0] new_credit;
    logic [CRW-1:0] cand;
    logic [AW:0]    j1_prev;

    tcts_slot_table #(.THREAD_SLOTS(THREAD_SLOTS)) u_slot_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rdata),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data)
    );

    tcts_run_list #(.THREAD_SLOTS(THREAD_SLOTS)) u_run_list (
        .i_clk     (i_clk),
        .i_rd_en   (rl_rd_en),
        .i_rd_addr (rl_rd_addr),
        .o_rd_data (rl_rdata),
        .i_wr_en   (rl_wr_en),
        .i_wr_addr (rl_wr_addr),
        .i_wr_data (rl_wr_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = tcts_pkg::CMP_W'(i_slot) < tcts_pkg::CMP_W'(THREAD_SLOTS);
    assign slot_valid = (st_rdata.cond == tcts_pkg::COND_LIVE) ||
                        (st_rdata.cond == tcts_pkg::COND_READY);
    assign walk_end   = (r_idx == r_count) && !r_v1 && !r_v2;
    assign j1_prev    = r_j1 - 1'b1;

    assign floor_credit = (st_rdata.credit < r_min_credit) ? r_min_credit : st_rdata.credit;
    assign half_sum     = (CRW + 1)'(st_rdata.credit >> 1) + (CRW + 1)'(st_rdata.prio);
    assign new_credit   = (half_sum > (CRW + 1)'(tcts_pkg::CREDIT_MAX)) ?
                          tcts_pkg::CREDIT_MAX : half_sum[CRW-1:0];
    assign cand         = (r_mode == W_RECOMP && st_rdata.cond != tcts_pkg::COND_DEAD) ?
                          new_credit : st_rdata.credit;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sidx      = r_sidx;
        n_np        = r_np;
        n_count     = r_count;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_v1        = 1'b0;
        n_j1        = r_j1;
        n_v2        = 1'b0;
        n_s2        = r_s2;
        n_found     = r_found;
        n_best      = r_best;
        n_pick      = r_pick;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        st_rd_en   = 1'b0;
        st_rd_addr = r_sidx;
        st_wr_en   = 1'b0;
        st_wr_addr = r_sidx;
        st_wr_data = st_rdata;
        rl_rd_en   = 1'b0;
        rl_rd_addr = r_idx[AW-1:0];
        rl_wr_en   = 1'b0;
        rl_wr_addr = r_count[AW-1:0];
        rl_wr_data = r_sidx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op          = tcts_pkg::t_op'(i_op);
                    n_sidx        = AW'(i_slot);
                    n_np          = i_new_priority;
                    n_res.status  = tcts_pkg::ST_REJECT;
                    n_res.pick    = '0;
                    n_res.picked  = 1'b0;
                    n_res.recomp  = 1'b0;
                    case (tcts_pkg::t_op'(i_op))
                        tcts_pkg::OP_SCHEDULE: begin
                            n_res.status = tcts_pkg::ST_DONE;
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_WALK;
                                n_mode  = W_SEARCH;
                                n_idx   = '0;
                                n_best  = '0;
                                n_pick  = '0;
                            end
                        end
                        tcts_pkg::OP_CREATE, tcts_pkg::OP_READY, tcts_pkg::OP_UNREADY,
                        tcts_pkg::OP_SET_PRIO, tcts_pkg::OP_FREE: begin
                            if (in_range) begin
                                st_rd_en   = 1'b1;
                                st_rd_addr = AW'(i_slot);
                                n_state    = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_state = S_DONE;
                case (r_op)
                    tcts_pkg::OP_CREATE: begin
                        if (!slot_valid) begin
                            st_wr_en          = 1'b1;
                            st_wr_data.prio   = r_def_prio;
                            st_wr_data.credit = CRW'(r_def_prio);
                            st_wr_data.cond   = tcts_pkg::COND_LIVE;
                            n_res.status      = tcts_pkg::ST_DONE;
                        end
                    end
                    tcts_pkg::OP_READY: begin
                        // a live slot is exactly a valid slot not on the run list
                        if (st_rdata.cond == tcts_pkg::COND_LIVE) begin
                            st_wr_en          = 1'b1;
                            st_wr_data.credit = floor_credit;
                            st_wr_data.cond   = tcts_pkg::COND_READY;
                            rl_wr_en          = 1'b1;
                            n_count           = r_count + 1'b1;
                            n_res.status      = tcts_pkg::ST_DONE;
                        end
                    end
                    tcts_pkg::OP_UNREADY, tcts_pkg::OP_FREE: begin
                        if (slot_valid) begin
                            st_wr_en          = 1'b1;
                            st_wr_data.credit = floor_credit;
                            st_wr_data.cond   = (r_op == tcts_pkg::OP_FREE) ?
                                                tcts_pkg::COND_DEAD : tcts_pkg::COND_LIVE;
                            n_res.status      = tcts_pkg::ST_DONE;
                            if (st_rdata.cond == tcts_pkg::COND_READY) begin
                                n_state = S_WALK;
                                n_mode  = W_REMOVE;
                                n_idx   = '0;
                                n_found = 1'b0;
                            end
                        end
                    end
                    tcts_pkg::OP_SET_PRIO: begin
                        if (slot_valid && r_np <= r_prio_limit) begin
                            st_wr_en        = 1'b1;
                            st_wr_data.prio = r_np;
                            n_res.status    = tcts_pkg::ST_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_WALK: begin
                // stage 0: run list read
                if (r_idx != r_count) begin
                    rl_rd_en = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_v1     = 1'b1;
                    n_j1     = r_idx;
                end
                // stage 1: run list word back
                if (r_v1) begin
                    if (r_mode == W_REMOVE) begin
                        // entries behind the removed slot move down by one
                        if (r_found) begin
                            rl_wr_en   = 1'b1;
                            rl_wr_addr = j1_prev[AW-1:0];
                            rl_wr_data = rl_rdata;
                        end else if (rl_rdata == r_sidx) begin
                            n_found = 1'b1;
                        end
                    end else begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = rl_rdata;
                        n_v2       = 1'b1;
                        n_s2       = rl_rdata;
                    end
                end
                // stage 2: slot entry back
                if (r_v2) begin
                    if (r_mode == W_RECOMP && st_rdata.cond != tcts_pkg::COND_DEAD) begin
                        st_wr_en          = 1'b1;
                        st_wr_addr        = r_s2;
                        st_wr_data.credit = new_credit;
                    end
                    if (cand > r_best) begin
                        n_best = cand;
                        n_pick = r_s2;
                    end
                end
                if (walk_end) begin
                    case (r_mode)
                        W_REMOVE: begin
                            n_count      = r_count - 1'b1;
                            n_res.status = tcts_pkg::ST_DONE;
                            n_state      = S_DONE;
                        end
                        W_SEARCH: begin
                            if (r_best != '0) begin
                                n_res.picked = 1'b1;
                                n_res.pick   = r_pick;
                                n_state      = S_DONE;
                            end else begin
                                n_mode = W_RECOMP;
                                n_idx  = '0;
                            end
                        end
                        W_RECOMP: begin
                            n_res.recomp = 1'b1;
                            if (r_best != '0) begin
                                n_res.picked = 1'b1;
                                n_res.pick   = r_pick;
                            end else begin
                                n_res.status = tcts_pkg::ST_NO_CREDIT;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_def_prio   <= tcts_pkg::DEF_PRIO_RST;
            r_prio_limit <= tcts_pkg::PRIO_LIMIT_RST;
            r_min_credit <= tcts_pkg::MIN_CREDIT_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcts_pkg::CFG_DEF_PRIO:   r_def_prio   <= i_cfg_data[PW-1:0];
                    tcts_pkg::CFG_PRIO_LIMIT: r_prio_limit <= i_cfg_data[PW-1:0];
                    tcts_pkg::CFG_MIN_CREDIT: r_min_credit <= i_cfg_data[CRW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sidx  <= n_sidx;
        r_np    <= n_np;
        r_mode  <= n_mode;
        r_idx   <= n_idx;
        r_j1    <= n_j1;
        r_s2    <= n_s2;
        r_found <= n_found;
        r_best  <= n_best;
        r_pick  <= n_pick;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_picked_slot  = tcts_pkg::SLOT_W'(r_out.pick);
    assign o_picked_valid = r_out.picked;
    assign o_recomputed   = r_out.recomp;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int SLOTS          = tcts_pkg::THREAD_SLOTS_DEF;
    localparam int PW             = tcts_pkg::PRIO_W;
    localparam int CRW            = tcts_pkg::CREDIT_W;
    localparam int SW             = tcts_pkg::SLOT_W;

    typedef struct packed {
        logic [tcts_pkg::STATUS_W-1:0] status;
        logic [SW-1:0]                 picked_slot;
        logic                          picked_valid;
        logic                          recomputed;
    } t_sched_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tcts_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tcts_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [tcts_pkg::OP_W-1:0]      i_op;
    logic [SW-1:0]                  i_slot;
    logic [PW-1:0]                  i_new_priority;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [tcts_pkg::STATUS_W-1:0]  o_status;
    logic [SW-1:0]                  o_picked_slot;
    logic                           o_picked_valid;
    logic                           o_recomputed;

    tick_credit_thread_scheduler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_new_priority (i_new_priority),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_picked_slot  (o_picked_slot),
        .o_picked_valid (o_picked_valid),
        .o_recomputed   (o_recomputed)
    );

    // scheduler state as the testbench sees it
    logic [PW-1:0]   slot_prio   [SLOTS];
    logic [CRW-1:0]  slot_credit [SLOTS];
    tcts_pkg::t_cond slot_cond   [SLOTS];
    logic [SW-1:0]   run_list    [$];
    logic [PW-1:0]   cfg_default_prio;
    logic [PW-1:0]   cfg_prio_limit;
    logic [CRW-1:0]  cfg_min_credit;

    t_sched_result expected_results [$];
    t_sched_result head_result;

    int fail_count;
    int word_count;
    int result_count;
    int cfg_write_count;
    int pick_count;
    int recompute_count;
    int no_credit_count;
    int idle_sched_count;
    int idle_cycles;
    bit tx_gaps;
    bit rx_idling;
    bit rx_hold_tgl;
    bit rx_hold_ack;
    int rx_hold_left;
    int rx_stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // next state and result word for one accepted op word
    function automatic t_sched_result apply_op(input tcts_pkg::t_op op, input logic [SW-1:0] s,
                                               input logic [PW-1:0] np);
        t_sched_result  r;
        logic [CRW-1:0] best;
        int             pos;
        int             sum;
        int             pass;
        bit             active;
        r = '0;
        r.status = tcts_pkg::ST_REJECT;
        active = (slot_cond[s] == tcts_pkg::COND_LIVE) || (slot_cond[s] == tcts_pkg::COND_READY);
        pos = -1;
        foreach (run_list[i]) begin
            if (run_list[i] == s) pos = i;
        end
        case (op)
            tcts_pkg::OP_SCHEDULE: begin
                r.status = tcts_pkg::ST_DONE;
                for (pass = 0; pass < 2 && run_list.size() > 0; pass++) begin
                    best = '0;
                    foreach (run_list[i]) begin
                        if (slot_credit[run_list[i]] > best) begin
                            best = slot_credit[run_list[i]];
                            r.picked_slot = run_list[i];
                        end
                    end
                    if (best != 0) begin
                        r.picked_valid = 1'b1;
                        break;
                    end
                    if (pass == 1) begin
                        r.status = tcts_pkg::ST_NO_CREDIT;
                        break;
                    end
                    // every listed credit is zero: halve and add priority
                    r.recomputed = 1'b1;
                    foreach (run_list[i]) begin
                        if (slot_cond[run_list[i]] != tcts_pkg::COND_DEAD) begin
                            sum = int'(slot_credit[run_list[i]] >> 1) +
                                  int'(slot_prio[run_list[i]]);
                            slot_credit[run_list[i]] = (sum > int'(tcts_pkg::CREDIT_MAX)) ?
                                                       tcts_pkg::CREDIT_MAX : CRW'(sum);
                        end
                    end
                end
                if (!r.picked_valid) r.picked_slot = '0;
                if (r.picked_valid) pick_count++;
                if (r.recomputed) recompute_count++;
                if (r.status == tcts_pkg::ST_NO_CREDIT) no_credit_count++;
                if (!r.picked_valid && r.status == tcts_pkg::ST_DONE) idle_sched_count++;
            end
            tcts_pkg::OP_CREATE: begin
                if (!active) begin
                    if (pos >= 0) run_list.delete(pos);
                    slot_prio[s]   = cfg_default_prio;
                    slot_credit[s] = CRW'(cfg_default_prio);
                    slot_cond[s]   = tcts_pkg::COND_LIVE;
                    r.status = tcts_pkg::ST_DONE;
                end
            end
            tcts_pkg::OP_READY: begin
                if (active && pos < 0 && run_list.size() < SLOTS) begin
                    if (slot_credit[s] < cfg_min_credit) slot_credit[s] = cfg_min_credit;
                    slot_cond[s] = tcts_pkg::COND_READY;
                    run_list.push_back(s);
                    r.status = tcts_pkg::ST_DONE;
                end
            end
            tcts_pkg::OP_UNREADY, tcts_pkg::OP_FREE: begin
                if (active) begin
                    slot_cond[s] = tcts_pkg::COND_LIVE;
                    if (slot_credit[s] < cfg_min_credit) slot_credit[s] = cfg_min_credit;
                    if (pos >= 0) run_list.delete(pos);
                    if (op == tcts_pkg::OP_FREE) slot_cond[s] = tcts_pkg::COND_DEAD;
                    r.status = tcts_pkg::ST_DONE;
                end
            end
            tcts_pkg::OP_SET_PRIO: begin
                if (active && np <= cfg_prio_limit) begin
                    slot_prio[s] = np;
                    r.status = tcts_pkg::ST_DONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input tcts_pkg::t_op op, input logic [SW-1:0] slot,
                             input logic [PW-1:0] prio);
        int gap;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_slot         <= slot;
        i_new_priority <= prio;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(apply_op(op, slot, prio));
        word_count++;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input tcts_pkg::t_cfg_idx idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= tcts_pkg::CFG_W'(val);
        case (idx)
            tcts_pkg::CFG_DEF_PRIO:   cfg_default_prio = PW'(val);
            tcts_pkg::CFG_PRIO_LIMIT: cfg_prio_limit   = PW'(val);
            tcts_pkg::CFG_MIN_CREDIT: cfg_min_credit   = CRW'(val);
            default: begin
            end
        endcase
        cfg_write_count++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int def_prio, input int prio_limit, input int min_credit);
        wait_results_drained();
        write_cfg(tcts_pkg::CFG_DEF_PRIO, def_prio);
        write_cfg(tcts_pkg::CFG_PRIO_LIMIT, prio_limit);
        write_cfg(tcts_pkg::CFG_MIN_CREDIT, min_credit);
    endtask

    task automatic send_random_word();
        int            pick;
        tcts_pkg::t_op op;
        logic [PW-1:0] np;
        pick = $urandom_range(0, 99);
        if (pick < 18)      op = tcts_pkg::OP_CREATE;
        else if (pick < 42) op = tcts_pkg::OP_READY;
        else if (pick < 52) op = tcts_pkg::OP_UNREADY;
        else if (pick < 66) op = tcts_pkg::OP_SET_PRIO;
        else if (pick < 86) op = tcts_pkg::OP_SCHEDULE;
        else if (pick < 95) op = tcts_pkg::OP_FREE;
        else                op = pick[0] ? tcts_pkg::OP_UNDEF7 : tcts_pkg::OP_UNDEF6;
        // mostly legal priorities, some anywhere in the field
        if ($urandom_range(0, 3) == 0) np = PW'($urandom);
        else                           np = PW'($urandom_range(0, cfg_prio_limit));
        send_word(op, SW'($urandom), np);
    endtask

    task automatic test_basic_ops();
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_CREATE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_CREATE, 4'd15, 6'd63);
        send_word(tcts_pkg::OP_CREATE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd7, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_SET_PRIO, 4'd15, 6'd63);
        send_word(tcts_pkg::OP_SET_PRIO, 4'd3, 6'd10);
        send_word(tcts_pkg::OP_READY, 4'd15, 6'd0);
        send_word(tcts_pkg::OP_SCHEDULE, 4'd15, 6'd63);
        send_word(tcts_pkg::OP_UNREADY, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_FREE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_UNREADY, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_FREE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_CREATE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_UNDEF6, 4'd15, 6'd63);
        send_word(tcts_pkg::OP_UNDEF7, 4'd0, 6'd0);
    endtask

    task automatic test_credit_recompute();
        set_config(0, 31, 0);
        send_word(tcts_pkg::OP_FREE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_FREE, 4'd15, 6'd0);
        send_word(tcts_pkg::OP_CREATE, 4'd3, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd3, 6'd0);
        // zero priority everywhere: still no credit after the recompute
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_SET_PRIO, 4'd3, 6'd32);
        send_word(tcts_pkg::OP_SET_PRIO, 4'd3, 6'd31);
        send_word(tcts_pkg::OP_CREATE, 4'd4, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd4, 6'd0);
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
        wait_results_drained();
        write_cfg(tcts_pkg::CFG_MIN_CREDIT, 127);
        send_word(tcts_pkg::OP_UNREADY, 4'd4, 6'd0);
        send_word(tcts_pkg::OP_READY, 4'd4, 6'd0);
        send_word(tcts_pkg::OP_SCHEDULE, 4'd0, 6'd0);
    endtask

    task automatic test_output_backpressure();
        int k;
        wait_results_drained();
        tx_gaps = 1'b0;
        @(posedge i_clk);
        rx_hold_tgl = !rx_hold_tgl;
        for (k = 0; k < 8; k++) send_random_word();
        wait_results_drained();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_phase(input int def_prio, input int prio_limit,
                                     input int min_credit, input int n_items);
        int k;
        set_config(def_prio, prio_limit, min_credit);
        for (k = 0; k < n_items; k++) begin
            send_random_word();
            if ($urandom_range(0, 49) == 0) wait_results_drained();
        end
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    always @(negedge i_clk) begin
        if (rx_hold_tgl != rx_hold_ack) begin
            rx_hold_ack  = rx_hold_tgl;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (!rx_idling) begin
            i_out_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("error: result word with none expected: status %0d slot %0d",
                             o_status, o_picked_slot);
            end else begin
                head_result = expected_results.pop_front();
                result_count++;
                if (o_status !== head_result.status ||
                    o_picked_slot !== head_result.picked_slot ||
                    o_picked_valid !== head_result.picked_valid ||
                    o_recomputed !== head_result.recomputed) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("error: result %0d: expected status %0d slot %0d valid %0d ",
                               result_count, head_result.status, head_result.picked_slot,
                               head_result.picked_valid);
                        $display("recomp %0d, got status %0d slot %0d valid %0d recomp %0d",
                                 head_result.recomputed, o_status, o_picked_slot,
                                 o_picked_valid, o_recomputed);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("error: no word moved for %0d cycles", STALL_LIMIT);
        $display("** tick_credit_thread_scheduler_unit: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_op           = '0;
        i_slot         = '0;
        i_new_priority = '0;
        tx_gaps        = 1'b1;
        rx_idling      = 1'b1;
        cfg_default_prio = tcts_pkg::DEF_PRIO_RST;
        cfg_prio_limit   = tcts_pkg::PRIO_LIMIT_RST;
        cfg_min_credit   = tcts_pkg::MIN_CREDIT_RST;
        foreach (slot_cond[i]) begin
            slot_prio[i]   = '0;
            slot_credit[i] = '0;
            slot_cond[i]   = tcts_pkg::COND_UNUSED;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_credit_recompute();
        test_output_backpressure();
        test_random_phase(8, 63, 4, 150);
        test_random_phase(0, 63, 0, 200);
        test_random_phase(0, 0, 0, 120);
        test_random_phase(63, 0, 127, 120);
        test_random_phase(0, 40, 0, 200);
        test_random_phase($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 2), 150);
        // last stretch runs with both sides always willing
        wait_results_drained();
        tx_gaps   = 1'b0;
        rx_idling = 1'b0;
        test_random_phase(1, 63, 0, 150);

        wait_results_drained();
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("error: %0d result words never arrived", expected_results.size());
        end
        $display("run: %0d op words, %0d results checked, %0d config writes",
                 word_count, result_count, cfg_write_count);
        $display("schedule: %0d picks, %0d recomputes, %0d without credit, %0d on empty list",
                 pick_count, recompute_count, no_credit_count, idle_sched_count);
        if (fail_count == 0)
            $display("** tick_credit_thread_scheduler_unit: PASSED **");
        else
            $display("** tick_credit_thread_scheduler_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/tcts_pkg.sv
design/tcts_slot_table.sv
design/tcts_run_list.sv
design/tick_credit_thread_scheduler_unit.sv
tb/sv/tb_top.sv
